FILE: rtl/pbsm_pkg.sv
package pbsm_pkg;

  // Sample and fixed-point formats of the smoothing filters.
  localparam int SAMPLE_BITS    = 10;
  localparam int FRACTION_BITS  = 8;
  localparam int STATE_BITS     = SAMPLE_BITS + FRACTION_BITS;

  // Datapath widths.
  localparam int BEND_BITS      = 14;
  localparam int ACC_BITS       = 26;
  localparam int NUM_BITS       = 23;
  localparam int MUL_B_BITS     = 14;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 13;
  localparam int STEP_BITS      = 4;
  localparam int COUNT_BITS     = 5;

  localparam logic [BEND_BITS-1:0]   BEND_CENTER       = 14'd8192;
  localparam logic [BEND_BITS-1:0]   BEND_MAX          = 14'd16383;
  localparam logic [7:0]             STATUS_PITCH_BEND = 8'hE0;
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_TOP        = '1;
  localparam logic [MUL_B_BITS-1:0]  SLIDER_LOW_SCALE  = 14'd8192;
  localparam logic [MUL_B_BITS-1:0]  SLIDER_HIGH_SCALE = 14'd8191;
  localparam logic [COUNT_BITS-1:0]  DIV_LAST_BIT      = COUNT_BITS'(NUM_BITS - 1);

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_PRESSURE_DEAD_ZONE  = 3'd0,
    REG_PRESSURE_FULL_TOUCH = 3'd1,
    REG_SLIDER_MIDDLE       = 3'd2,
    REG_SLIDER_DEAD_BAND    = 3'd3,
    REG_PRESSURE_BEND_SPAN  = 3'd4,
    REG_CHANGE_THRESHOLD    = 3'd5,
    REG_MIDI_CHANNEL        = 3'd6
  } reg_index_t;

  // Register values after reset.
  localparam logic [9:0]  RESET_DEAD_ZONE  = 10'd95;
  localparam logic [9:0]  RESET_FULL_TOUCH = 10'd550;
  localparam logic [9:0]  RESET_MIDDLE     = 10'd512;
  localparam logic [8:0]  RESET_DEAD_BAND  = 9'd32;
  localparam logic [12:0] RESET_BEND_SPAN  = 13'd2048;
  localparam logic [7:0]  RESET_THRESHOLD  = 8'd15;
  localparam logic [3:0]  RESET_CHANNEL    = 4'd0;

  // Datapath operations selected by the control word.
  typedef enum logic [3:0] {
    OP_IDLE     = 4'd0,
    OP_PSMOOTH  = 4'd1,
    OP_PSETUP   = 4'd2,
    OP_DIV      = 4'd3,
    OP_PACC     = 4'd4,
    OP_SSMOOTH  = 4'd5,
    OP_SSETUP   = 4'd6,
    OP_SACC     = 4'd7,
    OP_CLAMP    = 4'd8,
    OP_EMIT     = 4'd9
  } op_t;

  // Jump conditions of the sequencer.
  typedef enum logic [2:0] {
    JC_NONE       = 3'd0,
    JC_WAIT_INPUT = 3'd1,
    JC_SKIP       = 3'd2,
    JC_DIV_LOOP   = 3'd3,
    JC_OUT_FULL   = 3'd4
  } jump_t;

  typedef struct packed {
    op_t                  op;
    jump_t                cond;
    logic [STEP_BITS-1:0] target;
    logic                 fin;
  } ctrl_word_t;

  // Program addresses.
  localparam logic [STEP_BITS-1:0] STEP_IDLE    = 4'd0;
  localparam logic [STEP_BITS-1:0] STEP_PSMOOTH = 4'd1;
  localparam logic [STEP_BITS-1:0] STEP_PSETUP  = 4'd2;
  localparam logic [STEP_BITS-1:0] STEP_PDIV    = 4'd3;
  localparam logic [STEP_BITS-1:0] STEP_PACC    = 4'd4;
  localparam logic [STEP_BITS-1:0] STEP_SSMOOTH = 4'd5;
  localparam logic [STEP_BITS-1:0] STEP_SSETUP  = 4'd6;
  localparam logic [STEP_BITS-1:0] STEP_SDIV    = 4'd7;
  localparam logic [STEP_BITS-1:0] STEP_SACC    = 4'd8;
  localparam logic [STEP_BITS-1:0] STEP_CLAMP   = 4'd9;
  localparam logic [STEP_BITS-1:0] STEP_EMIT    = 4'd10;

  // Control store. Each word names an operation, an optional jump and
  // whether the program returns to the start after this step.
  function automatic ctrl_word_t microcode(input logic [STEP_BITS-1:0] addr);
    ctrl_word_t w;
    w = '{op: OP_IDLE, cond: JC_NONE, target: STEP_IDLE, fin: 1'b1};
    case (addr)
      STEP_IDLE:    w = '{op: OP_IDLE,    cond: JC_WAIT_INPUT, target: STEP_IDLE, fin: 1'b0};
      STEP_PSMOOTH: w = '{op: OP_PSMOOTH, cond: JC_NONE,       target: STEP_IDLE, fin: 1'b0};
      STEP_PSETUP:  w = '{op: OP_PSETUP,  cond: JC_SKIP,       target: STEP_PACC, fin: 1'b0};
      STEP_PDIV:    w = '{op: OP_DIV,     cond: JC_DIV_LOOP,   target: STEP_PDIV, fin: 1'b0};
      STEP_PACC:    w = '{op: OP_PACC,    cond: JC_NONE,       target: STEP_IDLE, fin: 1'b0};
      STEP_SSMOOTH: w = '{op: OP_SSMOOTH, cond: JC_NONE,       target: STEP_IDLE, fin: 1'b0};
      STEP_SSETUP:  w = '{op: OP_SSETUP,  cond: JC_SKIP,       target: STEP_SACC, fin: 1'b0};
      STEP_SDIV:    w = '{op: OP_DIV,     cond: JC_DIV_LOOP,   target: STEP_SDIV, fin: 1'b0};
      STEP_SACC:    w = '{op: OP_SACC,    cond: JC_NONE,       target: STEP_IDLE, fin: 1'b0};
      STEP_CLAMP:   w = '{op: OP_CLAMP,   cond: JC_NONE,       target: STEP_IDLE, fin: 1'b0};
      STEP_EMIT:    w = '{op: OP_EMIT,    cond: JC_OUT_FULL,   target: STEP_EMIT, fin: 1'b1};
      default:      w = '{op: OP_IDLE,    cond: JC_NONE,       target: STEP_IDLE, fin: 1'b1};
    endcase
    return w;
  endfunction

  // Quarter-weight exponential filter: (raw * 2^F + 3 * s) / 4, truncated.
  function automatic logic [STATE_BITS-1:0] smooth(input logic [STATE_BITS-1:0] s,
                                                   input logic [SAMPLE_BITS-1:0] raw);
    logic [STATE_BITS+1:0] sum;
    sum = (STATE_BITS+2)'({raw, {FRACTION_BITS{1'b0}}}) + (STATE_BITS+2)'(s)
          + (STATE_BITS+2)'({s, 1'b0});
    return sum[STATE_BITS+1:2];
  endfunction

endpackage

FILE: rtl/pitch_bend_sensor_mapper_core.sv
// Pitch-bend sensor mapper.
// Input channel: in_valid / in_stall carry one sample tick (raw_pressure, raw_slider).
// Output channel: out_valid / out_stall carry one MIDI pitch-bend message
// (status_byte, bend_low, bend_high, bend_value); a tick gives zero or one message.
// Configuration: cfg_write with cfg_index and cfg_data writes one register at a
// clock edge; indexes beyond the register list are ignored. Write only while idle.
// A small control store sequences one shared multiplier and a restoring divider
// that produces one quotient bit per cycle. A mapping that needs no division skips
// its divider steps. After the emit step the sequencer is back at idle, where the
// next tick is taken, so a new tick is not taken until the last one is through.
// A message appears on the output in the cycle after its emit step.
// The input stalls while a tick is in progress. The output register holds a
// message until it is transferred; a new tick may be taken meanwhile, and the
// emit step waits while the output register holds a stalled message.
// Reset (rst, synchronous) restores the register defaults, clears the pressure
// filter, sets the slider filter to 512.0 and the last sent bend to center,
// and drops out_valid.
module pitch_bend_sensor_mapper_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [pbsm_pkg::SAMPLE_BITS-1:0]    raw_pressure,
  input  logic [pbsm_pkg::SAMPLE_BITS-1:0]    raw_slider,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [7:0]                          status_byte,
  output logic [6:0]                          bend_low,
  output logic [6:0]                          bend_high,
  output logic [pbsm_pkg::BEND_BITS-1:0]      bend_value,
  input  logic                                cfg_write,
  input  logic [pbsm_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [pbsm_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  localparam int SB = pbsm_pkg::SAMPLE_BITS;
  localparam int ST = pbsm_pkg::STATE_BITS;
  localparam int AB = pbsm_pkg::ACC_BITS;
  localparam int NB = pbsm_pkg::NUM_BITS;
  localparam logic signed [AB-1:0] ACC_CENTER = AB'(pbsm_pkg::BEND_CENTER);
  localparam logic signed [AB-1:0] ACC_MAX    = AB'(pbsm_pkg::BEND_MAX);

  // Configuration registers.
  logic [9:0]  dead_zone;
  logic [9:0]  full_touch;
  logic [9:0]  slider_middle;
  logic [8:0]  dead_band;
  logic [12:0] bend_span;
  logic [7:0]  threshold;
  logic [3:0]  channel;

  // Sequencer.
  logic [pbsm_pkg::STEP_BITS-1:0] step;
  logic [pbsm_pkg::STEP_BITS-1:0] step_next;
  pbsm_pkg::ctrl_word_t           cw;
  logic                           take_jump;

  // Filter and message state.
  logic [ST-1:0]                      pressure_smoothed;
  logic [ST-1:0]                      slider_smoothed;
  logic [pbsm_pkg::BEND_BITS-1:0]     last_sent;

  // Working registers.
  logic [SB-1:0]                      rp;
  logic [SB-1:0]                      rs;
  logic                               p_active;
  logic                               neg;
  logic                               s_below_r;
  logic [NB-1:0]                      quo;
  logic [SB-1:0]                      rem;
  logic [SB-1:0]                      den;
  logic [pbsm_pkg::COUNT_BITS-1:0]    cnt;
  logic signed [AB-1:0]               acc;
  logic [pbsm_pkg::BEND_BITS-1:0]     tgt;

  // Combinational datapath signals.
  logic [SB-1:0]                      p_int;
  logic [SB-1:0]                      p_clamped;
  logic signed [SB:0]                 p_diff;
  logic signed [SB:0]                 p_den;
  logic [SB-1:0]                      p_diff_mag;
  logic [SB-1:0]                      p_den_mag;
  logic                               p_skip;
  logic [SB-1:0]                      s_int;
  logic signed [SB:0]                 s_lo;
  logic [SB:0]                        s_hi;
  logic                               s_below;
  logic                               s_above;
  logic                               s_skip;
  logic [SB-1:0]                      s_den;
  logic [SB-1:0]                      mul_a;
  logic [pbsm_pkg::MUL_B_BITS-1:0]    mul_b;
  logic [SB+pbsm_pkg::MUL_B_BITS-1:0] product;
  logic [SB:0]                        div_trial;
  logic                               div_ge;
  logic [SB:0]                        div_diff;
  logic signed [AB-1:0]               q_ext;
  logic signed [pbsm_pkg::BEND_BITS:0] send_diff;
  logic [pbsm_pkg::BEND_BITS-1:0]     send_mag;
  logic                               send;
  logic                               out_hold;
  logic                               emit_load;

  // Current control word.
  assign cw = pbsm_pkg::microcode(step);

  assign in_stall  = (cw.op != pbsm_pkg::OP_IDLE);
  assign out_hold  = out_valid && out_stall;

  // Pressure mapping operands.
  always_comb begin
    p_int      = pressure_smoothed[ST-1:pbsm_pkg::FRACTION_BITS];
    p_clamped  = (p_int > full_touch) ? full_touch : p_int;
    p_diff     = $signed({1'b0, p_clamped}) - $signed({1'b0, dead_zone});
    p_den      = $signed({1'b0, full_touch}) - $signed({1'b0, dead_zone});
    p_diff_mag = p_diff[SB] ? SB'(-p_diff) : p_diff[SB-1:0];
    p_den_mag  = p_den[SB] ? SB'(-p_den) : p_den[SB-1:0];
    p_skip     = !p_active || (p_den == '0);
  end

  // Slider mapping operands.
  always_comb begin
    s_int   = slider_smoothed[ST-1:pbsm_pkg::FRACTION_BITS];
    s_lo    = $signed({1'b0, slider_middle}) - $signed({2'b00, dead_band});
    s_hi    = {1'b0, slider_middle} + {2'b00, dead_band};
    s_below = $signed({1'b0, s_int}) < s_lo;
    s_above = {1'b0, s_int} > s_hi;
    s_skip  = !s_below && !s_above;
    s_den   = s_below ? s_lo[SB-1:0] : SB'(pbsm_pkg::SAMPLE_TOP - s_hi[SB-1:0]);
  end

  // Shared multiplier: the numerator of each range mapping.
  always_comb begin
    if (cw.op == pbsm_pkg::OP_PSETUP) begin
      mul_a = p_diff_mag;
      mul_b = pbsm_pkg::MUL_B_BITS'(bend_span);
    end else if (s_below) begin
      mul_a = s_int;
      mul_b = pbsm_pkg::SLIDER_LOW_SCALE;
    end else begin
      mul_a = SB'(s_int - s_hi[SB-1:0]);
      mul_b = pbsm_pkg::SLIDER_HIGH_SCALE;
    end
    product = (SB + pbsm_pkg::MUL_B_BITS)'(mul_a) * (SB + pbsm_pkg::MUL_B_BITS)'(mul_b);
  end

  // One restoring division step.
  always_comb begin
    div_trial = {rem, quo[NB-1]};
    div_ge    = div_trial >= {1'b0, den};
    div_diff  = div_trial - {1'b0, den};
    q_ext     = $signed({{(AB-NB){1'b0}}, quo});
  end

  // Resend decision.
  always_comb begin
    send_diff = $signed({1'b0, tgt}) - $signed({1'b0, last_sent});
    send_mag  = send_diff[pbsm_pkg::BEND_BITS] ? pbsm_pkg::BEND_BITS'(-send_diff)
                                               : send_diff[pbsm_pkg::BEND_BITS-1:0];
    send      = (send_mag > pbsm_pkg::BEND_BITS'(threshold))
                || ((tgt == pbsm_pkg::BEND_CENTER) && (last_sent != pbsm_pkg::BEND_CENTER));
    emit_load = (cw.op == pbsm_pkg::OP_EMIT) && !out_hold && send;
  end

  // Next program address.
  always_comb begin
    case (cw.cond)
      pbsm_pkg::JC_WAIT_INPUT: take_jump = !in_valid;
      pbsm_pkg::JC_SKIP:       take_jump = (cw.op == pbsm_pkg::OP_PSETUP) ? p_skip : s_skip;
      pbsm_pkg::JC_DIV_LOOP:   take_jump = (cnt != '0);
      pbsm_pkg::JC_OUT_FULL:   take_jump = out_hold;
      default:                 take_jump = 1'b0;
    endcase
    if (take_jump) begin
      step_next = cw.target;
    end else if (cw.fin) begin
      step_next = pbsm_pkg::STEP_IDLE;
    end else begin
      step_next = step + pbsm_pkg::STEP_BITS'(1);
    end
  end

  // Control, configuration and filter state.
  always_ff @(posedge clk) begin
    if (rst) begin
      step              <= pbsm_pkg::STEP_IDLE;
      out_valid         <= 1'b0;
      pressure_smoothed <= '0;
      slider_smoothed   <= ST'({pbsm_pkg::RESET_MIDDLE, {pbsm_pkg::FRACTION_BITS{1'b0}}});
      last_sent         <= pbsm_pkg::BEND_CENTER;
      dead_zone         <= pbsm_pkg::RESET_DEAD_ZONE;
      full_touch        <= pbsm_pkg::RESET_FULL_TOUCH;
      slider_middle     <= pbsm_pkg::RESET_MIDDLE;
      dead_band         <= pbsm_pkg::RESET_DEAD_BAND;
      bend_span         <= pbsm_pkg::RESET_BEND_SPAN;
      threshold         <= pbsm_pkg::RESET_THRESHOLD;
      channel           <= pbsm_pkg::RESET_CHANNEL;
    end else begin
      step <= step_next;

      // Output register: loaded by the emit step, freed by a transfer.
      if (emit_load) begin
        out_valid <= 1'b1;
        last_sent <= tgt;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      // Filters: a pressure reading below the dead zone reloads its filter.
      case (cw.op)
        pbsm_pkg::OP_PSMOOTH: begin
          if (rp >= dead_zone) begin
            pressure_smoothed <= pbsm_pkg::smooth(pressure_smoothed, rp);
          end else begin
            pressure_smoothed <= {rp, {pbsm_pkg::FRACTION_BITS{1'b0}}};
          end
        end
        pbsm_pkg::OP_SSMOOTH: slider_smoothed <= pbsm_pkg::smooth(slider_smoothed, rs);
        default: ;
      endcase

      // Register writes; unknown indexes are dropped.
      if (cfg_write) begin
        case (cfg_index)
          pbsm_pkg::REG_PRESSURE_DEAD_ZONE:  dead_zone     <= cfg_data[9:0];
          pbsm_pkg::REG_PRESSURE_FULL_TOUCH: full_touch    <= cfg_data[9:0];
          pbsm_pkg::REG_SLIDER_MIDDLE:       slider_middle <= cfg_data[9:0];
          pbsm_pkg::REG_SLIDER_DEAD_BAND:    dead_band     <= cfg_data[8:0];
          pbsm_pkg::REG_PRESSURE_BEND_SPAN:  bend_span     <= cfg_data[12:0];
          pbsm_pkg::REG_CHANGE_THRESHOLD:    threshold     <= cfg_data[7:0];
          pbsm_pkg::REG_MIDI_CHANNEL:        channel       <= cfg_data[3:0];
          default: ;
        endcase
      end
    end
  end

  // Datapath registers driven by the control word.
  always_ff @(posedge clk) begin
    case (cw.op)
      pbsm_pkg::OP_IDLE: begin
        if (in_valid) begin
          rp <= raw_pressure;
          rs <= raw_slider;
        end
      end
      pbsm_pkg::OP_PSMOOTH: begin
        p_active <= (rp >= dead_zone);
        acc      <= ACC_CENTER;
      end
      pbsm_pkg::OP_PSETUP: begin
        neg <= p_diff[SB] ^ p_den[SB];
        den <= p_den_mag;
        rem <= '0;
        cnt <= pbsm_pkg::DIV_LAST_BIT;
        quo <= p_skip ? '0 : product[NB-1:0];
      end
      pbsm_pkg::OP_DIV: begin
        rem <= div_ge ? div_diff[SB-1:0] : div_trial[SB-1:0];
        quo <= {quo[NB-2:0], div_ge};
        cnt <= cnt - pbsm_pkg::COUNT_BITS'(1);
      end
      pbsm_pkg::OP_PACC: acc <= acc + (neg ? -q_ext : q_ext);
      pbsm_pkg::OP_SSETUP: begin
        s_below_r <= s_below && !s_skip;
        den       <= s_den;
        rem       <= '0;
        cnt       <= pbsm_pkg::DIV_LAST_BIT;
        quo       <= s_skip ? '0 : product[NB-1:0];
      end
      pbsm_pkg::OP_SACC: acc <= acc + (s_below_r ? q_ext - ACC_CENTER : q_ext);
      pbsm_pkg::OP_CLAMP: begin
        if (acc < 0) begin
          tgt <= '0;
        end else if (acc > ACC_MAX) begin
          tgt <= pbsm_pkg::BEND_MAX;
        end else begin
          tgt <= acc[pbsm_pkg::BEND_BITS-1:0];
        end
      end
      pbsm_pkg::OP_EMIT: begin
        if (emit_load) begin
          status_byte <= pbsm_pkg::STATUS_PITCH_BEND | {4'b0000, channel};
          bend_low    <= tgt[6:0];
          bend_high   <= tgt[13:7];
          bend_value  <= tgt;
        end
      end
      default: ;
    endcase
  end

endmodule

FILE: rtl/pbsm_checker.sv
module pbsm_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  status_byte,
  input logic [6:0]  bend_low,
  input logic [6:0]  bend_high,
  input logic [13:0] bend_value
);

  // Reset empties the output register.
  a_reset_empties: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // A message carries a pitch-bend status and consistent bend fields.
  a_message_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status_byte[7:4] == 4'hE) && (bend_low == bend_value[6:0])
                  && (bend_high == bend_value[13:7]))
    else $error("inconsistent pitch-bend message");

  // One tick is worked at a time: the input stalls right after a transfer.
  a_one_tick: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second tick taken while one is in progress");

  // A stalled message stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid && $stable(bend_value) && $stable(status_byte))
    else $error("stalled message changed");

endmodule

bind pitch_bend_sensor_mapper_core pbsm_checker u_pbsm_checker (.*);

FILE: verif/tb.sv
module tb;
  import pbsm_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  // Cycles a tick may still be in progress after the last message came out.
  localparam int DRAIN_CYCLES = 80;
  localparam int IDLE_PERCENT = 34;
  localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] pressure;
    logic [SAMPLE_BITS-1:0] slider;
  } sensor_tick_t;

  typedef struct packed {
    logic [7:0]           status;
    logic [6:0]           low;
    logic [6:0]           high;
    logic [BEND_BITS-1:0] value;
  } bend_msg_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [SAMPLE_BITS-1:0] raw_pressure = '0;
  logic [SAMPLE_BITS-1:0] raw_slider = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] status_byte;
  logic [6:0] bend_low;
  logic [6:0] bend_high;
  logic [BEND_BITS-1:0] bend_value;
  logic cfg_write = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  // Register copies kept by the predictor.
  logic [9:0]  cfg_dead_zone  = RESET_DEAD_ZONE;
  logic [9:0]  cfg_full_touch = RESET_FULL_TOUCH;
  logic [9:0]  cfg_middle     = RESET_MIDDLE;
  logic [8:0]  cfg_dead_band  = RESET_DEAD_BAND;
  logic [12:0] cfg_bend_span  = RESET_BEND_SPAN;
  logic [7:0]  cfg_threshold  = RESET_THRESHOLD;
  logic [3:0]  cfg_channel    = RESET_CHANNEL;

  // Filter and change-detection state of the predictor.
  logic [STATE_BITS-1:0] pressure_filt = '0;
  logic [STATE_BITS-1:0] slider_filt = STATE_BITS'(512) << FRACTION_BITS;
  longint last_bend = 8192;

  sensor_tick_t pending_ticks_q[$];
  bend_msg_t    bend_msgs_q[$];
  int  err_count = 0;
  int  cycle_count = 0;
  bit  calm = 1'b0;

  pitch_bend_sensor_mapper_core u_dut (.*);

  always #2 clk = ~clk;

  function automatic logic [STATE_BITS-1:0] filter_step(input logic [STATE_BITS-1:0] s,
                                                        input logic [SAMPLE_BITS-1:0] raw);
    longint acc;
    acc = (longint'(raw) << FRACTION_BITS) + 3 * longint'(s);
    return STATE_BITS'(acc >> 2);
  endfunction

  // Linear map with truncating division; a zero-width input range maps to 0.
  function automatic longint scale_range(input longint x, input longint in_lo,
                                         input longint in_hi, input longint out_lo,
                                         input longint out_hi);
    if (in_hi == in_lo) return 0;
    return (x - in_lo) * (out_hi - out_lo) / (in_hi - in_lo) + out_lo;
  endfunction

  // Advances the predicted state by one tick; returns 1 when a message is due.
  function automatic bit predict_bend_msg(input logic [SAMPLE_BITS-1:0] rp,
                                          input logic [SAMPLE_BITS-1:0] rs,
                                          output bend_msg_t msg);
    longint dead, full, mid, band, span, v, lo, hi, off_p, off_s, target, diff;
    logic [BEND_BITS-1:0] t;
    dead = cfg_dead_zone;
    full = cfg_full_touch;
    mid = cfg_middle;
    band = cfg_dead_band;
    span = cfg_bend_span;
    off_p = 0;
    off_s = 0;
    msg = '0;

    // Pressure: below the dead zone the filter is reloaded and adds no bend.
    if (longint'(rp) >= dead) begin
      pressure_filt = filter_step(pressure_filt, rp);
      v = pressure_filt >> FRACTION_BITS;
      if (v > full) v = full;
      off_p = scale_range(v, dead, full, 0, span);
    end else begin
      pressure_filt = STATE_BITS'(rp) << FRACTION_BITS;
    end

    // Slider: neutral band around the middle, full swing either side.
    slider_filt = filter_step(slider_filt, rs);
    v = slider_filt >> FRACTION_BITS;
    lo = mid - band;
    hi = mid + band;
    if (v < lo) off_s = scale_range(v, 0, lo, -8192, 0);
    else if (v > hi) off_s = scale_range(v, hi, longint'(SAMPLE_TOP), 0, 8191);

    target = longint'(BEND_CENTER) + off_p + off_s;
    if (target > longint'(BEND_MAX)) target = longint'(BEND_MAX);
    if (target < 0) target = 0;

    // Resend on a large enough move, or on an exact return to center.
    diff = target - last_bend;
    if (diff < 0) diff = -diff;
    if (diff > longint'(cfg_threshold) ||
        (target == longint'(BEND_CENTER) && last_bend != longint'(BEND_CENTER))) begin
      last_bend = target;
      t = target[BEND_BITS-1:0];
      msg.status = STATUS_PITCH_BEND | {4'h0, cfg_channel};
      msg.low = t[6:0];
      msg.high = t[13:7];
      msg.value = t;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch in %s at cycle %0d: got %0d, expected %0d", what, cycle_count, got,
             want);
    err_count++;
  endtask

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Input driver: predicts each transfer and presents the next pending tick.
  always @(posedge clk) begin
    sensor_tick_t nxt;
    bend_msg_t msg;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        if (predict_bend_msg(raw_pressure, raw_slider, msg)) bend_msgs_q.push_back(msg);
      end
      if (!in_valid || !in_stall) begin
        if (pending_ticks_q.size() > 0 && (calm || $urandom_range(99) >= IDLE_PERCENT)) begin
          nxt = pending_ticks_q.pop_front();
          raw_pressure <= nxt.pressure;
          raw_slider <= nxt.slider;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output monitor: checks each message transfer against the oldest prediction.
  always @(posedge clk) begin
    bend_msg_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (bend_msgs_q.size() == 0) begin
          report_mismatch("unexpected message, bend_value", bend_value, -1);
        end else begin
          want = bend_msgs_q.pop_front();
          if (status_byte !== want.status) report_mismatch("status_byte", status_byte,
                                                           want.status);
          if (bend_low !== want.low) report_mismatch("bend_low", bend_low, want.low);
          if (bend_high !== want.high) report_mismatch("bend_high", bend_high, want.high);
          if (bend_value !== want.value) report_mismatch("bend_value", bend_value,
                                                         want.value);
        end
      end
      out_stall <= !calm && ($urandom_range(99) < IDLE_PERCENT);
    end
  end

  function automatic int clip_sample(input int x);
    if (x < 0) return 0;
    if (x > int'(SAMPLE_TOP)) return int'(SAMPLE_TOP);
    return x;
  endfunction

  task automatic add_tick(input int p, input int s);
    sensor_tick_t t;
    t.pressure = SAMPLE_BITS'(clip_sample(p));
    t.slider = SAMPLE_BITS'(clip_sample(s));
    pending_ticks_q.push_back(t);
  endtask

  // Random gestures: mostly held positions with jitter, some releases to
  // center, and some unrelated noise.
  task automatic add_gestures(input int count);
    int added, len, kind, p, s, i;
    added = 0;
    while (added < count) begin
      kind = $urandom_range(9);
      if (kind < 2) begin
        len = $urandom_range(1, 4);
        for (i = 0; i < len; i++) add_tick($urandom_range(1023), $urandom_range(1023));
      end else if (kind < 8) begin
        case ($urandom_range(3))
          0: p = $urandom_range(int'(cfg_dead_zone));
          1: p = int'(cfg_dead_zone) + $urandom_range(4) - 2;
          2: p = int'(cfg_full_touch) + $urandom_range(4) - 2;
          default: p = $urandom_range(1023);
        endcase
        case ($urandom_range(3))
          0: s = int'(cfg_middle) - int'(cfg_dead_band) + $urandom_range(4) - 2;
          1: s = int'(cfg_middle) + int'(cfg_dead_band) + $urandom_range(4) - 2;
          2: s = int'(cfg_middle) + $urandom_range(2 * int'(cfg_dead_band))
                 - int'(cfg_dead_band);
          default: s = $urandom_range(1023);
        endcase
        len = $urandom_range(1, 24);
        for (i = 0; i < len; i++)
          add_tick(p + $urandom_range(6) - 3, s + $urandom_range(6) - 3);
      end else begin
        len = $urandom_range(6, 20);
        for (i = 0; i < len; i++) begin
          p = (cfg_dead_zone > 0) ? $urandom_range(int'(cfg_dead_zone) - 1) : 0;
          add_tick(p, int'(cfg_middle) + $urandom_range(2));
        end
      end
      added += len;
    end
  endtask

  // Waits until every tick has been transferred and every message checked,
  // then lets any tick that gives no message finish.
  task automatic wait_quiet();
    do @(negedge clk);
    while (pending_ticks_q.size() > 0 || in_valid || bend_msgs_q.size() > 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_PRESSURE_DEAD_ZONE:  cfg_dead_zone = data[9:0];
      REG_PRESSURE_FULL_TOUCH: cfg_full_touch = data[9:0];
      REG_SLIDER_MIDDLE:       cfg_middle = data[9:0];
      REG_SLIDER_DEAD_BAND:    cfg_dead_band = data[8:0];
      REG_PRESSURE_BEND_SPAN:  cfg_bend_span = data[12:0];
      REG_CHANGE_THRESHOLD:    cfg_threshold = data[7:0];
      REG_MIDI_CHANNEL:        cfg_channel = data[3:0];
      default: ;
    endcase
  endtask

  task automatic write_all(input int dead, input int full, input int mid, input int band,
                           input int span, input int thr, input int chan);
    write_reg(REG_PRESSURE_DEAD_ZONE, CFG_DATA_BITS'(dead));
    write_reg(REG_PRESSURE_FULL_TOUCH, CFG_DATA_BITS'(full));
    write_reg(REG_SLIDER_MIDDLE, CFG_DATA_BITS'(mid));
    write_reg(REG_SLIDER_DEAD_BAND, CFG_DATA_BITS'(band));
    write_reg(REG_PRESSURE_BEND_SPAN, CFG_DATA_BITS'(span));
    write_reg(REG_CHANGE_THRESHOLD, CFG_DATA_BITS'(thr));
    write_reg(REG_MIDI_CHANNEL, CFG_DATA_BITS'(chan));
  endtask

  initial begin
    int i;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed ticks at the reset settings: field extremes, a full swing,
    // a return to exact center, and readings around the dead zone, the
    // full-touch point and both edges of the slider band.
    add_tick(0, 512);
    for (i = 0; i < 3; i++) add_tick(1023, 1023);
    for (i = 0; i < 4; i++) add_tick(0, 0);
    for (i = 0; i < 6; i++) add_tick(0, 512);
    add_tick(94, 480);
    add_tick(95, 479);
    add_tick(95, 544);
    add_tick(550, 545);
    add_tick(551, 545);
    add_tick(1023, 0);
    add_tick(1023, 1023);
    add_gestures(250);
    wait_quiet();

    // Fully random settings, inverted ranges allowed.
    write_all($urandom_range(1023), $urandom_range(1, 1023), $urandom_range(1023),
              $urandom_range(511), $urandom_range(8191), $urandom_range(255),
              $urandom_range(15));
    add_gestures(290);
    wait_quiet();

    // Low extremes; the channel write carries bits above the register.
    write_all(0, 1023, 0, 0, 8191, 0, 13'h1FFF);
    add_gestures(290);
    wait_quiet();

    // High extremes with an inverted pressure range, no pressure span, a
    // too-wide threshold write and a write to an unused index.
    write_all(1023, 1, 1023, 511, 0, 13'h1FFF, 0);
    write_reg(REG_UNUSED, CFG_DATA_BITS'($urandom));
    add_gestures(290);
    wait_quiet();

    // Zero-width pressure range and no slider band.
    write_all(300, 300, 512, 0, $urandom_range(8191), $urandom_range(40),
              $urandom_range(15));
    add_gestures(150);
    wait_quiet();

    // Realistic random settings, run without any idling on either side.
    write_all($urandom_range(20, 200), $urandom_range(300, 1000), $urandom_range(300, 700),
              $urandom_range(100), $urandom_range(8191), $urandom_range(40),
              $urandom_range(15));
    calm = 1'b1;
    add_gestures(200);
    wait_quiet();
    calm = 1'b0;

    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
